>>> rtl/fls_pkg.sv
package fls_pkg;

    // Table size and field widths.
    localparam int SLOTS      = 256;
    localparam int OWNER_BITS = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Request kinds carried in tuser.
    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_MISMATCH = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

>>> rtl/fls_ctrl.sv
module fls_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    output logic         o_s_ready,
    input  logic         i_m_ready,
    output logic         o_m_valid,
    output fls_pkg::t_cmd o_cmd
);
    import fls_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The output register can take a new result when empty or draining.
    assign out_free = !r_out_valid || i_m_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and input handshake.
    always_comb begin
        o_s_ready     = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag: set by a commit, cleared when the item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

>>> rtl/fls_dpath.sv
module fls_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fls_pkg::t_cmd                i_cmd,
    input  logic                         i_func,
    input  logic [fls_pkg::OWNER_BITS-1:0] i_owner,
    input  logic [fls_pkg::SLOT_W-1:0]   i_slot,
    output logic [fls_pkg::SLOT_W-1:0]   o_slot_out,
    output logic [1:0]                   o_status,
    output logic [fls_pkg::CNT_W-1:0]    o_live_count,
    output logic [fls_pkg::CNT_W-1:0]    o_high_water
);
    import fls_pkg::*;

    // Owner table and free stack memories.
    logic [OWNER_BITS-1:0] r_owner_mem [SLOTS];
    logic [SLOT_W-1:0]     r_stack_mem [SLOTS];
    logic [OWNER_BITS-1:0] r_owner_rd;
    logic [SLOT_W-1:0]     r_stack_rd;

    // Per-slot valid bits and counters.
    logic [SLOTS-1:0]      r_valid;
    logic [SLOTS-1:0]      n_valid;
    logic [CNT_W-1:0]      r_free_depth;
    logic [CNT_W-1:0]      n_free_depth;
    logic [CNT_W-1:0]      r_used_mark;
    logic [CNT_W-1:0]      n_used_mark;
    logic [CNT_W-1:0]      r_live;
    logic [CNT_W-1:0]      n_live;

    // Latched request.
    t_func                 r_func;
    logic [OWNER_BITS-1:0] r_owner;
    logic [SLOT_W-1:0]     r_slot;

    // Result register.
    logic [SLOT_W-1:0]     r_out_slot;
    t_status               r_out_status;
    logic [CNT_W-1:0]      r_out_live;
    logic [CNT_W-1:0]      r_out_high;

    logic                  pop_ok;
    logic                  fresh_ok;
    logic                  granted;
    logic [SLOT_W-1:0]     grant_slot;
    logic                  release_ok;
    logic                  do_alloc;
    logic                  do_release;
    logic [SLOT_W-1:0]     n_out_slot;
    t_status               n_out_status;

    // Decision for the request in flight.
    assign pop_ok     = (r_free_depth != '0);
    assign fresh_ok   = (r_used_mark < CNT_W'(SLOTS));
    assign granted    = pop_ok || fresh_ok;
    assign grant_slot = pop_ok ? r_stack_rd : r_used_mark[SLOT_W-1:0];
    assign release_ok = ({1'b0, r_slot} < r_used_mark) && r_valid[r_slot] &&
                        (r_owner_rd == r_owner);
    assign do_alloc   = i_cmd.commit && (r_func == FUNC_ALLOC) && granted;
    assign do_release = i_cmd.commit && (r_func == FUNC_RELEASE) && release_ok;

    // Next values of the allocator state and the result.
    always_comb begin
        n_valid      = r_valid;
        n_free_depth = r_free_depth;
        n_used_mark  = r_used_mark;
        n_live       = r_live;
        n_out_slot   = '0;
        n_out_status = STAT_OK;
        if (r_func == FUNC_ALLOC) begin
            if (granted) begin
                n_out_slot          = grant_slot;
                n_valid[grant_slot] = 1'b1;
                if (pop_ok) begin
                    n_free_depth = r_free_depth - 1'b1;
                end else begin
                    n_used_mark = r_used_mark + 1'b1;
                end
                if (r_live < CNT_W'(SLOTS)) begin
                    n_live = r_live + 1'b1;
                end
            end else begin
                n_out_status = STAT_FULL;
            end
        end else begin
            n_out_slot = r_slot;
            if (release_ok) begin
                n_valid[r_slot] = 1'b0;
                if (r_free_depth < CNT_W'(SLOTS)) begin
                    n_free_depth = r_free_depth + 1'b1;
                end
                if (r_live != '0) begin
                    n_live = r_live - 1'b1;
                end
            end else begin
                n_out_status = STAT_MISMATCH;
            end
        end
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_func);
            r_owner <= i_owner;
            r_slot  <= i_slot;
        end
    end

    // Owner table: read on capture, written on a granted allocate.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_owner_rd <= r_owner_mem[i_slot];
        end
        if (do_alloc) begin
            r_owner_mem[grant_slot] <= r_owner;
        end
    end

    // Free stack: top read on capture, pushed on a successful release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_stack_rd <= r_stack_mem[SLOT_W'(r_free_depth - 1'b1)];
        end
        if (do_release && (r_free_depth < CNT_W'(SLOTS))) begin
            r_stack_mem[r_free_depth[SLOT_W-1:0]] <= r_slot;
        end
    end

    // Allocator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_free_depth <= '0;
            r_used_mark  <= '0;
            r_live       <= '0;
        end else if (i_cmd.commit) begin
            r_valid      <= n_valid;
            r_free_depth <= n_free_depth;
            r_used_mark  <= n_used_mark;
            r_live       <= n_live;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_slot   <= n_out_slot;
            r_out_status <= n_out_status;
            r_out_live   <= n_live;
            r_out_high   <= n_used_mark;
        end
    end

    assign o_slot_out   = r_out_slot;
    assign o_status     = r_out_status;
    assign o_live_count = r_out_live;
    assign o_high_water = r_out_high;

    // Every slot below the mark is either held or on the free stack.
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_free_depth} + {1'b0, r_live}) == {1'b0, r_used_mark})
        else $error("free depth plus live count differs from the high-water mark");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOTS))
        else $error("live count above the table size");

    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_alloc |=> r_valid[$past(grant_slot)])
        else $error("granted slot not marked valid");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_release |=> !r_valid[$past(r_slot)])
        else $error("released slot still marked valid");

endmodule

>>> rtl/free_list_slot_allocator.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: owner_handle, slot_index
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: slot_out, status, live_count, high_water
//
// Each request is handled in order: the owner table and free stack top are first read
// from their memories, then the request is decided, state updated and the result loaded.
// A new request is taken while the previous result waits in the output register.
// If that register is still full, the decision cycle waits until it drains.
// Reset (i_rst_n low, synchronous) empties the table, the stack and all counters.
module free_list_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [fls_pkg::IN_DATA_W-1:0] s_axis_tdata,  // owner_handle[15:0], slot_index[23:16]
    input  logic        s_axis_tuser,                    // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [fls_pkg::OUT_DATA_W-1:0] m_axis_tdata  // slot_out[7:0], status[9:8],
                                                         // live_count[18:10],
                                                         // high_water[27:19], zero[31:28]
);
    import fls_pkg::*;

    t_cmd              cmd;
    logic [SLOT_W-1:0] slot_out;
    logic [1:0]        status;
    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  high_water;

    // Sequencing of requests and the output handshake.
    fls_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // Tables, counters and the result register.
    fls_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (s_axis_tuser),
        .i_owner      (s_axis_tdata[OWNER_BITS-1:0]),
        .i_slot       (s_axis_tdata[OWNER_BITS +: SLOT_W]),
        .o_slot_out   (slot_out),
        .o_status     (status),
        .o_live_count (live_count),
        .o_high_water (high_water)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {4'b0000, high_water, live_count, status, slot_out};

endmodule
